@@ rtl/bpe_pkg.sv @@
package bpe_pkg;

  // Field widths fixed by the item formats.
  localparam int unsigned T_PARAM_W   = 20;
  localparam int unsigned NODE_IDX_W  = 4;
  localparam int unsigned COORD_W     = 16;
  localparam int unsigned CURVE_CNT_W = 4;
  // Bezier coefficients c0..c3 of 17-bit control points fit in 22 signed bits.
  localparam int unsigned COEF_W      = COORD_W + 6;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sh7FFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 16'sh8000;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_EVAL  = 1'b1
  } cmd_e;

  typedef enum logic {
    ST_OK        = 1'b0,
    ST_NO_CURVES = 1'b1
  } status_e;

  typedef struct packed {
    cmd_e                        cmd;
    logic [NODE_IDX_W-1:0]       node_index;
    logic signed [COORD_W-1:0]   pos_x;
    logic signed [COORD_W-1:0]   pos_y;
    logic signed [COORD_W-1:0]   tan_in_x;
    logic signed [COORD_W-1:0]   tan_in_y;
    logic signed [COORD_W-1:0]   tan_out_x;
    logic signed [COORD_W-1:0]   tan_out_y;
    logic [T_PARAM_W-1:0]        t_param;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]   point_x;
    logic signed [COORD_W-1:0]   point_y;
    logic [CURVE_CNT_W-1:0]      segment;
    status_e                     status;
  } out_item_t;

  // x in the low half, y in the high half
  typedef struct packed {
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } vec_t;

  // Node data for one curve: start node and end node
  typedef struct packed {
    vec_t a_pos;
    vec_t a_tout;
    vec_t b_pos;
    vec_t b_tin;
  } node_rd_t;

  // Sideband that travels with each evaluate item
  typedef struct packed {
    logic                   valid;
    status_e                status;
    logic [CURVE_CNT_W-1:0] seg;
  } ctl_t;

endpackage

@@ rtl/bpe_node_store.sv @@
module bpe_node_store #(
  parameter int unsigned MAX_NODES = 16
) (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic [bpe_pkg::NODE_IDX_W-1:0]  wa_i,
  input  bpe_pkg::vec_t                   wpos_i,
  input  bpe_pkg::vec_t                   wtin_i,
  input  bpe_pkg::vec_t                   wtout_i,
  input  logic                            re_i,
  input  logic [bpe_pkg::NODE_IDX_W-1:0]  ra_i,
  output bpe_pkg::node_rd_t               rd_o
);
  import bpe_pkg::*;

  localparam int unsigned NODE_SLOTS = 2 ** NODE_IDX_W;
  localparam int unsigned DEPTH      = (MAX_NODES < NODE_SLOTS) ? MAX_NODES : NODE_SLOTS;
  localparam int unsigned ADDR_W     = $clog2(DEPTH);

  vec_t pos_mem  [DEPTH];
  vec_t tin_mem  [DEPTH];
  vec_t tout_mem [DEPTH];

  logic [NODE_IDX_W:0] rb;
  logic                wr_ok, a_ok, b_ok;
  logic                a_ok_q, b_ok_q;
  vec_t                a_pos_q, a_tout_q, b_pos_q, b_tin_q;

  assign rb    = {1'b0, ra_i} + (NODE_IDX_W+1)'(1);
  assign wr_ok = 32'(wa_i) < MAX_NODES;
  assign a_ok  = 32'(ra_i) < MAX_NODES;
  assign b_ok  = 32'(rb) < MAX_NODES;

  always_ff @(posedge clk_i) begin
    if (we_i && wr_ok) begin
      pos_mem[wa_i[ADDR_W-1:0]]  <= wpos_i;
      tin_mem[wa_i[ADDR_W-1:0]]  <= wtin_i;
      tout_mem[wa_i[ADDR_W-1:0]] <= wtout_i;
    end
  end

  // port A: start node, port B: end node
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      a_pos_q  <= pos_mem[ra_i[ADDR_W-1:0]];
      a_tout_q <= tout_mem[ra_i[ADDR_W-1:0]];
      b_pos_q  <= pos_mem[rb[ADDR_W-1:0]];
      b_tin_q  <= tin_mem[rb[ADDR_W-1:0]];
      a_ok_q   <= a_ok;
      b_ok_q   <= b_ok;
    end
  end

  // slots past the store read as zero vectors
  assign rd_o.a_pos  = a_ok_q ? a_pos_q  : '0;
  assign rd_o.a_tout = a_ok_q ? a_tout_q : '0;
  assign rd_o.b_pos  = b_ok_q ? b_pos_q  : '0;
  assign rd_o.b_tin  = b_ok_q ? b_tin_q  : '0;

endmodule

@@ rtl/bpe_mac.sv @@
module bpe_mac #(
  parameter int unsigned AW = 22,
  parameter int unsigned FW = 17,
  parameter int unsigned OW = 39
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [AW-1:0] a_i,
  input  logic [FW-1:0]        f_i,
  input  logic signed [OW-1:0] addend_i,
  output logic signed [OW-1:0] sum_o
);
  // sum = a * f + addend, two stages: partial products, then shift-add
  localparam int unsigned CH  = 24;
  localparam int unsigned NCH = (AW + CH - 1) / CH;
  localparam int unsigned PW  = CH + FW + 2;

  logic signed [PW-1:0] pp_d [NCH];
  logic signed [PW-1:0] pp_q [NCH];
  logic signed [OW-1:0] addend_q, sum_d, sum_q;

  for (genvar j = 0; j < NCH; j++) begin : g_chunk
    localparam int unsigned LO = j * CH;
    localparam int unsigned HI = (j == NCH - 1) ? AW - 1 : LO + CH - 1;
    logic signed [CH:0] chunk;
    if (j == NCH - 1) begin : g_top
      assign chunk = (CH+1)'($signed(a_i[HI:LO]));
    end else begin : g_low
      assign chunk = $signed({1'b0, a_i[HI:LO]});
    end
    assign pp_d[j] = chunk * $signed({1'b0, f_i});
  end

  always_comb begin
    sum_d = addend_q;
    for (int j = 0; j < NCH; j++) begin
      sum_d = sum_d + (OW'(pp_q[j]) <<< (j * CH));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_q     <= pp_d;
      addend_q <= addend_i;
      sum_q    <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

@@ rtl/bezier_path_evaluator_unit.sv @@
// Piecewise cubic Bezier path evaluator.
// Input channel (in_valid_i / in_stall_o / in_item_i) carries two kinds of item.
// A write item (cmd = write) stores node position and both tangents in slot
// node_index; it gives no result. An evaluate item (cmd = eval) gives one result
// item: the point at t_param, the curve used and a status.
// curve_count is loaded through cfg_we_i / cfg_wdata_i; the user must load it
// only while the block is idle, which the block does not enforce. Throughput:
// one item per cycle unless the receiver stalls, write and evaluate items mixed
// freely. Each item passes node read, coefficients, three two-stage Horner
// steps and round/saturate into the output register. Each Horner step is a
// multiply-add by the fraction, cut into 24-bit partial products. A write is
// visible to an evaluate item accepted on the next cycle.
// Receiver stall: the whole pipeline holds while the output register is full
// and out_stall_i is high; in_stall_o follows, nothing is dropped or repeated.
// Reset clears curve_count (no curves: evaluate gives status 1 and zero point)
// and all valid bits. Node slots hold garbage until written.
module bezier_path_evaluator_unit #(
  parameter int unsigned MAX_NODES = 16,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  bpe_pkg::in_item_t                in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output bpe_pkg::out_item_t               out_item_o,
  input  logic                             cfg_we_i,
  input  logic [bpe_pkg::CURVE_CNT_W-1:0]  cfg_wdata_i
);
  import bpe_pkg::*;

  localparam int unsigned FW     = FRAC_BITS + 1;
  // accumulator widths after each Horner step (one more sign bit than needed)
  localparam int unsigned A1W    = COEF_W + FRAC_BITS + 1;
  localparam int unsigned A2W    = A1W + FW;
  localparam int unsigned A3W    = A2W + FW;
  localparam int unsigned RND_SH = 3 * FRAC_BITS;
  localparam int unsigned QW     = A3W - RND_SH;
  // t_param split: at least one integer bit even when FRAC_BITS covers it all
  localparam int unsigned TXW    = (T_PARAM_W > FRAC_BITS) ? T_PARAM_W : FRAC_BITS + 1;
  localparam int unsigned IPW    = TXW - FRAC_BITS;
  localparam int unsigned CMPW   = (IPW > CURVE_CNT_W) ? IPW : CURVE_CNT_W;
  localparam int unsigned NCTL   = 8;
  localparam int unsigned NF     = 6;
  localparam logic [FW-1:0] F_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [CURVE_CNT_W-1:0] curve_count_q;

  logic adv, acc_in, acc_wr, acc_ev;

  logic [TXW-1:0]         t_ext;
  logic [IPW-1:0]         int_part;
  logic [CURVE_CNT_W-1:0] last_seg, seg_d;
  logic                   over, no_curves;
  logic [FW-1:0]          f_d;
  ctl_t                   ctl_d;

  ctl_t                   ctl_q [NCTL];
  logic [FW-1:0]          f_q   [NF];

  vec_t                   wpos, wtin, wtout;
  node_rd_t               rd;

  logic signed [COORD_W-1:0] pt [2];

  logic      out_valid_q;
  out_item_t out_item_q;

  // ---------------------------------------------------------------
  // Handshake: pipeline moves whenever the output register can take
  // ---------------------------------------------------------------
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;
  assign acc_in     = in_valid_i && adv;
  assign acc_wr     = acc_in && (in_item_i.cmd == CMD_WRITE);
  assign acc_ev     = acc_in && (in_item_i.cmd == CMD_EVAL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curve_count_q <= '0;
    end else if (cfg_we_i) begin
      curve_count_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------
  // Front end: pick the curve and the fraction
  // ---------------------------------------------------------------
  assign t_ext     = TXW'(in_item_i.t_param);
  assign int_part  = t_ext[TXW-1:FRAC_BITS];
  assign last_seg  = curve_count_q - CURVE_CNT_W'(1);
  assign no_curves = (curve_count_q == '0);
  assign over      = CMPW'(int_part) > CMPW'(last_seg);
  assign seg_d     = over ? last_seg : CURVE_CNT_W'(int_part);
  // clamping the index leaves a fraction of at least one, so it becomes one
  assign f_d       = over ? F_ONE : {1'b0, t_ext[FRAC_BITS-1:0]};

  assign ctl_d.valid  = acc_ev;
  assign ctl_d.status = no_curves ? ST_NO_CURVES : ST_OK;
  assign ctl_d.seg    = seg_d;

  assign wpos  = '{y: in_item_i.pos_y,     x: in_item_i.pos_x};
  assign wtin  = '{y: in_item_i.tan_in_y,  x: in_item_i.tan_in_x};
  assign wtout = '{y: in_item_i.tan_out_y, x: in_item_i.tan_out_x};

  // stage R0: node read
  bpe_node_store #(
    .MAX_NODES (MAX_NODES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (acc_wr),
    .wa_i    (in_item_i.node_index),
    .wpos_i  (wpos),
    .wtin_i  (wtin),
    .wtout_i (wtout),
    .re_i    (adv),
    .ra_i    (seg_d),
    .rd_o    (rd)
  );

  // sideband and fraction delay lines
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NCTL; i++) begin
        ctl_q[i] <= '0;
      end
    end else if (adv) begin
      ctl_q[0] <= ctl_d;
      for (int i = 1; i < NCTL; i++) begin
        ctl_q[i] <= ctl_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_q[0] <= f_d;
      for (int i = 1; i < NF; i++) begin
        f_q[i] <= f_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------
  // Per axis: coefficients (R1), three Horner steps (R2..R7), rounding
  // ---------------------------------------------------------------
  for (genvar ax = 0; ax < 2; ax++) begin : g_axis
    logic signed [COORD_W-1:0] p0s, p3s, tos, tis;
    logic signed [COEF_W-1:0]  p0, p1, p2, p3, tout, e2, g3;
    logic signed [COEF_W-1:0]  c1_d, c2_d, c3_d;
    logic signed [COEF_W-1:0]  c2_q, c3_q;
    logic signed [COEF_W-1:0]  c1_pipe_q [3];
    logic signed [COORD_W-1:0] c0_pipe_q [5];
    logic signed [A1W-1:0]     acc1;
    logic signed [A2W-1:0]     acc2;
    logic signed [A3W-1:0]     acc3;
    logic signed [QW-1:0]      q;
    logic                      in_range;

    assign p0s = (ax == 0) ? rd.a_pos.x  : rd.a_pos.y;
    assign tos = (ax == 0) ? rd.a_tout.x : rd.a_tout.y;
    assign p3s = (ax == 0) ? rd.b_pos.x  : rd.b_pos.y;
    assign tis = (ax == 0) ? rd.b_tin.x  : rd.b_tin.y;

    assign p0   = COEF_W'(p0s);
    assign p3   = COEF_W'(p3s);
    assign tout = COEF_W'(tos);
    assign p1   = p0 + tout;
    assign p2   = p3 + COEF_W'(tis);

    // c1 = 3(p1-p0), c2 = 3(p0-2p1+p2), c3 = p3-p0+3(p1-p2)
    assign c1_d = (tout <<< 1) + tout;
    assign e2   = p0 - (p1 <<< 1) + p2;
    assign c2_d = (e2 <<< 1) + e2;
    assign g3   = p1 - p2;
    assign c3_d = p3 - p0 + (g3 <<< 1) + g3;

    always_ff @(posedge clk_i) begin
      if (adv) begin
        c3_q         <= c3_d;
        c2_q         <= c2_d;
        c1_pipe_q[0] <= c1_d;
        c0_pipe_q[0] <= p0s;
        for (int i = 1; i < 3; i++) begin
          c1_pipe_q[i] <= c1_pipe_q[i-1];
        end
        for (int i = 1; i < 5; i++) begin
          c0_pipe_q[i] <= c0_pipe_q[i-1];
        end
      end
    end

    // acc1 = c3*f + c2*s
    bpe_mac #(
      .AW (COEF_W),
      .FW (FW),
      .OW (A1W)
    ) u_mac1 (
      .clk_i    (clk_i),
      .en_i     (adv),
      .a_i      (c3_q),
      .f_i      (f_q[1]),
      .addend_i (A1W'(c2_q) <<< FRAC_BITS),
      .sum_o    (acc1)
    );

    // acc2 = acc1*f + c1*s^2
    bpe_mac #(
      .AW (A1W),
      .FW (FW),
      .OW (A2W)
    ) u_mac2 (
      .clk_i    (clk_i),
      .en_i     (adv),
      .a_i      (acc1),
      .f_i      (f_q[3]),
      .addend_i (A2W'(c1_pipe_q[2]) <<< (2 * FRAC_BITS)),
      .sum_o    (acc2)
    );

    // acc3 = acc2*f + c0*s^3 + s^3/2 (rounding half folded into the addend)
    bpe_mac #(
      .AW (A2W),
      .FW (FW),
      .OW (A3W)
    ) u_mac3 (
      .clk_i    (clk_i),
      .en_i     (adv),
      .a_i      (acc2),
      .f_i      (f_q[5]),
      .addend_i (A3W'($signed({c0_pipe_q[4], 1'b1, {(RND_SH-1){1'b0}}}))),
      .sum_o    (acc3)
    );

    // floor after the half add: round to nearest, ties up; then saturate
    assign q        = acc3[A3W-1:RND_SH];
    assign in_range = (&q[QW-1:COORD_W-1]) || !(|q[QW-1:COORD_W-1]);
    assign pt[ax]   = in_range ? q[COORD_W-1:0] : (q[QW-1] ? COORD_MIN : COORD_MAX);
  end

  // ---------------------------------------------------------------
  // Output register (R8)
  // ---------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= ctl_q[NCTL-1].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (ctl_q[NCTL-1].status == ST_NO_CURVES) begin
        out_item_q.point_x <= '0;
        out_item_q.point_y <= '0;
        out_item_q.segment <= '0;
        out_item_q.status  <= ST_NO_CURVES;
      end else begin
        out_item_q.point_x <= pt[0];
        out_item_q.point_y <= pt[1];
        out_item_q.segment <= ctl_q[NCTL-1].seg;
        out_item_q.status  <= ST_OK;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  a_stall_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output is free");

  a_eval_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_in && in_item_i.cmd == CMD_EVAL) |=> ctl_q[0].valid)
    else $error("accepted evaluate item lost at pipeline entry");

  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_in && in_item_i.cmd == CMD_WRITE) |=> !ctl_q[0].valid)
    else $error("write item entered the evaluate pipeline");

  a_pipe_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> (ctl_q[NCTL-1] == $past(ctl_q[NCTL-1])))
    else $error("pipeline moved during stall");

  a_no_curves_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status == ST_NO_CURVES) |->
      (out_item_o.point_x == '0 && out_item_o.point_y == '0 && out_item_o.segment == '0))
    else $error("no-curve result carries nonzero fields");

endmodule

@@ dv/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bpe_pkg::*;

  localparam int unsigned NODE_SLOTS = 16;
  localparam int unsigned FRAC_BITS  = 16;
  // wait long enough for any item to leave the pipeline
  localparam int unsigned DRAIN_CYCLES = 12;
  // cycles without any item moving on either side before the run is declared hung
  localparam int unsigned HANG_LIMIT = 4000;
  localparam int unsigned PHASE_ITEMS = 150;

  // ------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of the node store and curve count,
  // predicts each evaluate item at the moment it is accepted, and checks
  // results in order.
  // ------------------------------------------------------------------------
  class path_scoreboard;
    logic [CURVE_CNT_W-1:0] curves;
    vec_t                   node_pos[NODE_SLOTS];
    vec_t                   node_tin[NODE_SLOTS];
    vec_t                   node_tout[NODE_SLOTS];
    out_item_t              point_q[$];
    int                     errors;

    function new();
      curves = '0;
      errors = 0;
    endfunction

    function void set_curves(logic [CURVE_CNT_W-1:0] n);
      curves = n;
    endfunction

    function int pending();
      return point_q.size();
    endfunction

    // One axis of the cubic: Horner form on exact integers scaled by 2^48,
    // half an LSB added, then floor (ties go up) and saturate.
    function logic signed [COORD_W-1:0] bezier_axis(longint p0, longint p1, longint p2,
                                                     longint p3, longint frac);
      logic signed [127:0] c0, c1, c2, c3, ff, acc;
      c0  = p0;
      c1  = 3 * (p1 - p0);
      c2  = 3 * (p0 - 2 * p1 + p2);
      c3  = p3 - 3 * p2 + 3 * p1 - p0;
      ff  = frac;
      acc = c3 * ff + (c2 <<< FRAC_BITS);
      acc = acc * ff + (c1 <<< (2 * FRAC_BITS));
      acc = acc * ff + (c0 <<< (3 * FRAC_BITS));
      acc = acc + (128'sd1 <<< (3 * FRAC_BITS - 1));
      acc = acc >>> (3 * FRAC_BITS);
      if (acc > COORD_MAX) return COORD_MAX;
      if (acc < COORD_MIN) return COORD_MIN;
      return acc[COORD_W-1:0];
    endfunction

    function void note_input(in_item_t it);
      out_item_t             exp_pt;
      int unsigned           seg;
      longint                frac;
      logic [NODE_IDX_W-1:0] na, nb;
      vec_t                  a, ta, b, tb;
      longint                ax, ay, tax, tay, bx, by, tbx, tby;
      if (it.cmd == CMD_WRITE) begin
        node_pos[it.node_index]  = '{y: it.pos_y, x: it.pos_x};
        node_tin[it.node_index]  = '{y: it.tan_in_y, x: it.tan_in_x};
        node_tout[it.node_index] = '{y: it.tan_out_y, x: it.tan_out_x};
        return;
      end
      exp_pt = '0;
      if (curves == 0) begin
        exp_pt.status = ST_NO_CURVES;
      end else begin
        seg = it.t_param >> FRAC_BITS;
        if (seg > curves - 1) seg = curves - 1;
        frac = it.t_param - (seg << FRAC_BITS);
        if (frac > (64'd1 << FRAC_BITS)) frac = 64'd1 << FRAC_BITS;
        na  = seg[NODE_IDX_W-1:0];
        nb  = na + NODE_IDX_W'(1);
        a   = node_pos[na];
        ta  = node_tout[na];
        b   = node_pos[nb];
        tb  = node_tin[nb];
        ax  = $signed(a.x);  ay  = $signed(a.y);
        tax = $signed(ta.x); tay = $signed(ta.y);
        bx  = $signed(b.x);  by  = $signed(b.y);
        tbx = $signed(tb.x); tby = $signed(tb.y);
        exp_pt.point_x = bezier_axis(ax, ax + tax, bx + tbx, bx, frac);
        exp_pt.point_y = bezier_axis(ay, ay + tay, by + tby, by, frac);
        exp_pt.segment = seg[CURVE_CNT_W-1:0];
        exp_pt.status  = ST_OK;
      end
      point_q.push_back(exp_pt);
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t exp_pt;
      if (point_q.size() == 0) begin
        report_mismatch("result item with no evaluate item waiting");
        return;
      end
      exp_pt = point_q.pop_front();
      if (got.point_x !== exp_pt.point_x)
        report_mismatch($sformatf("point_x got %0d want %0d",
                                  $signed(got.point_x), $signed(exp_pt.point_x)));
      if (got.point_y !== exp_pt.point_y)
        report_mismatch($sformatf("point_y got %0d want %0d",
                                  $signed(got.point_y), $signed(exp_pt.point_y)));
      if (got.segment !== exp_pt.segment)
        report_mismatch($sformatf("segment got %0d want %0d", got.segment, exp_pt.segment));
      if (got.status !== exp_pt.status)
        report_mismatch($sformatf("status got %0d want %0d", got.status, exp_pt.status));
    endtask
  endclass

  // ------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // ------------------------------------------------------------------------
  logic                   clk_i;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  in_item_t               in_item_i   = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  out_item_t              out_item_o;
  logic                   cfg_we_i    = 1'b0;
  logic [CURVE_CNT_W-1:0] cfg_wdata_i = '0;

  path_scoreboard board = new();

  // idle percentages for the sender and the receiver, changed per phase
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned quiet_cycles = 0;

  bezier_path_evaluator_unit #(
    .MAX_NODES (NODE_SLOTS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Receiver back-pressure: a fresh coin each cycle, independent of valid.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Result monitor: values are read at the edge, before this step's updates land.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_result(out_item_o);
  end

  // Hang detector: counts consecutive cycles in which no item moves on either side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------------------
  // Item builders. Fields that a command ignores get random junk.
  // ------------------------------------------------------------------------
  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(9)) inside
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      [2:4]:   return COORD_W'($urandom_range(1023)) - COORD_W'(512);
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic logic [T_PARAM_W-1:0] rand_t_param();
    logic [3:0] whole;
    whole = 4'($urandom_range(15));
    case ($urandom_range(7))
      0:       return {whole, 16'h0000};
      1:       return {whole, 16'hFFFF};
      2:       return {whole, 16'h8000};
      default: return T_PARAM_W'($urandom);
    endcase
  endfunction

  function automatic in_item_t node_item(logic [NODE_IDX_W-1:0] slot, vec_t pos, vec_t tin,
                                         vec_t tout);
    in_item_t it;
    it.cmd        = CMD_WRITE;
    it.node_index = slot;
    it.pos_x      = pos.x;
    it.pos_y      = pos.y;
    it.tan_in_x   = tin.x;
    it.tan_in_y   = tin.y;
    it.tan_out_x  = tout.x;
    it.tan_out_y  = tout.y;
    it.t_param    = T_PARAM_W'($urandom);
    return it;
  endfunction

  function automatic in_item_t eval_item(logic [T_PARAM_W-1:0] t);
    in_item_t it;
    it            = node_item(4'($urandom), vec_t'($urandom), vec_t'($urandom),
                              vec_t'($urandom));
    it.cmd        = CMD_EVAL;
    it.t_param    = t;
    return it;
  endfunction

  function automatic vec_t rand_vec();
    return '{y: rand_coord(), x: rand_coord()};
  endfunction

  // ------------------------------------------------------------------------
  // Drivers
  // ------------------------------------------------------------------------
  // Present one item, with random idle cycles ahead of it; returns in the step
  // of the accepting edge without touching valid, so back-to-back items keep it high.
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_input(it);
  endtask

  // Register writes only on an idle block: all results back, then let any
  // trailing node writes leave the pipeline.
  task automatic load_curve_count(input logic [CURVE_CNT_W-1:0] n);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= n;
    board.set_curves(n);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // ------------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned curve_plan[9];
    int unsigned cc;
    vec_t        hi_vec, lo_vec, zero_vec;

    // 16 stands for a random nonzero curve count
    curve_plan = '{15, 1, 0, 16, 15, 2, 16, 0, 15};
    hi_vec     = '{y: COORD_MAX, x: COORD_MAX};
    lo_vec     = '{y: COORD_MIN, x: COORD_MIN};
    zero_vec   = '0;

    tx_idle_pct = 21;
    rx_idle_pct = 85;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed ---
    // empty path: status flags the error, point and segment are zero
    load_curve_count(0);
    send_item(eval_item(20'h00000));
    send_item(eval_item(20'hFFFFF));

    // Load every slot before any curve is live. Nodes 0/1 give a tiny curve
    // whose midpoint sits exactly on half an LSB (+0.5 in x, -0.5 in y).
    // The rest alternate between full-scale corners so curves overshoot.
    send_item(node_item(4'd0, '{y: -16'sd1, x: 16'sd1}, zero_vec, zero_vec));
    send_item(node_item(4'd1, zero_vec, zero_vec, zero_vec));
    for (int k = 2; k < NODE_SLOTS; k++) begin
      send_item(node_item(NODE_IDX_W'(k), (k % 2 == 0) ? hi_vec : lo_vec, lo_vec, hi_vec));
    end

    load_curve_count(15);
    send_item(eval_item(20'h00000));      // start of first curve
    send_item(eval_item(20'h08000));      // rounding tie, both signs
    send_item(eval_item(20'h22000));      // overshoot above full scale
    send_item(eval_item(20'h2E000));      // overshoot below full scale
    send_item(eval_item(20'hFFFFF));      // index clamped, fraction above one

    load_curve_count(1);
    send_item(eval_item(20'h10000));      // index clamped, fraction exactly one
    send_item(eval_item(20'h08000));

    // --- random phases ---
    // Thirds: sender light / receiver heavy, then swapped, then no idling.
    for (int ph = 0; ph < 9; ph++) begin
      case (ph / 3)
        0:       begin tx_idle_pct = 21; rx_idle_pct = 85; end
        1:       begin tx_idle_pct = 85; rx_idle_pct = 21; end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase
      cc = (curve_plan[ph] == 16) ? $urandom_range(15, 1) : curve_plan[ph];
      load_curve_count(CURVE_CNT_W'(cc));
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(2) == 0) begin
          send_item(node_item(NODE_IDX_W'($urandom), rand_vec(), rand_vec(), rand_vec()));
        end else begin
          send_item(eval_item(rand_t_param()));
        end
      end
    end

    // --- drain ---
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (2 * DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
